// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
// assertion macros shared by the sha-256 hasher checker
// no dependencies; pulled in by `include where assertions are written
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication under reset
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sha256bsh_pkg.sv -----
// shared types and constants of the sha-256 byte stream hasher
// no dependencies; used by controller, datapath and top level
package sha256bsh_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int CHAIN_WORDS = 8;

    // round constants
    localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial hash value
    localparam logic [31:0] INIT_HASH [0:CHAIN_WORDS-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [3:0] BIT_COUNT_STEP = 4'd8;

    // source of a byte shifted into the block buffer
    typedef enum logic [1:0] {
        BSEL_DATA = 2'd0,
        BSEL_MARK = 2'd1,
        BSEL_ZERO = 2'd2
    } byte_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      shift_byte;
        byte_sel_t byte_sel;
        logic      shift_len;
        logic      comp_load;
        logic      round;
        logic      fold;
        logic      emit;
        logic      restart;
    } sha_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_is_63;
        logic fill_is_56;
        logic round_last;
        logic emit_last;
        logic out_free;
    } sha_stat_t;

endpackage

// ----- rtl/sha256bsh_ctrl.sv -----
// control state machine of the sha-256 byte stream hasher
// depends on sha256bsh_pkg for the command and status structs
module sha256bsh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   s_axis_tready,
    input  sha256bsh_pkg::sha_stat_t stat,
    output sha256bsh_pkg::sha_cmd_t  cmd
);
    import sha256bsh_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PAD_MARK  = 8'b0000_0010,
        ST_PAD_ZERO  = 8'b0000_0100,
        ST_PAD_LEN   = 8'b0000_1000,
        ST_COMP_LOAD = 8'b0001_0000,
        ST_ROUND     = 8'b0010_0000,
        ST_FOLD      = 8'b0100_0000,
        ST_DIGEST    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // state and return point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.byte_sel = BSEL_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.shift_byte = s_axis_tuser;
                    if (s_axis_tuser && stat.fill_is_63)
                    begin
                        state_next = ST_COMP_LOAD;
                        ret_next   = s_axis_tlast ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_MARK;
                if (stat.fill_is_63)
                begin
                    state_next = ST_COMP_LOAD;
                    ret_next   = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (stat.fill_is_56)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.byte_sel   = BSEL_ZERO;
                    if (stat.fill_is_63)
                    begin
                        state_next = ST_COMP_LOAD;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.shift_len = 1'b1;
                state_next    = ST_COMP_LOAD;
                ret_next      = ST_DIGEST;
            end
            ST_COMP_LOAD:
            begin
                cmd.comp_load = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            ST_DIGEST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sha256bsh_datapath.sv -----
// datapath of the sha-256 byte stream hasher: block buffer and schedule window,
// working variables, chaining words, counters and output register; uses sha256bsh_pkg
module sha256bsh_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256bsh_pkg::sha_cmd_t  cmd,
    output sha256bsh_pkg::sha_stat_t stat,
    input  logic [7:0]             data_byte,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tvalid,
    output logic [31:0]            digest_word,
    output logic [2:0]             word_index,
    output logic                   last_word
);
    import sha256bsh_pkg::*;

    // block buffer doubling as the message schedule window, word 0 oldest
    logic [0:15][31:0] win_reg, win_next;
    logic [31:0]       work_reg [0:7];
    logic [31:0]       work_next [0:7];
    logic [31:0]       chain_reg [0:7];
    logic [31:0]       chain_next [0:7];
    logic [6:0]        fill_reg, fill_next;
    logic [63:0]       bits_reg, bits_next;
    logic [5:0]        rnd_reg, rnd_next;
    logic [2:0]        emit_idx_reg, emit_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_word_reg, out_word_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic [7:0]        byte_in;
    logic [31:0]       sched_w, t1, t2;

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // status toward the controller
    assign stat.fill_is_63 = (fill_reg == 7'(BLOCK_BYTES - 1));
    assign stat.fill_is_56 = (fill_reg == 7'(BLOCK_BYTES - 8));
    assign stat.round_last = (rnd_reg == 6'(ROUNDS - 1));
    assign stat.emit_last  = (emit_idx_reg == 3'(CHAIN_WORDS - 1));
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

    // byte source
    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_MARK: byte_in = PAD_MARK_BYTE;
            default:   byte_in = 8'h00;
        endcase
    end

    // round and schedule arithmetic
    always_comb
    begin
        sched_w = sml_sig1(win_reg[14]) + win_reg[9] + sml_sig0(win_reg[1]) + win_reg[0];
        t1 = work_reg[7] + big_sig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + ROUND_K[rnd_reg] + win_reg[0];
        t2 = big_sig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // buffer, working variables and chaining words
    always_comb
    begin
        win_next   = win_reg;
        work_next  = work_reg;
        chain_next = chain_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        if (cmd.shift_byte)
        begin
            win_next  = (win_reg << 8) | {504'd0, byte_in};
            fill_next = fill_reg + 7'd1;
            if (cmd.byte_sel == BSEL_DATA)
            begin
                bits_next = bits_reg + {60'd0, BIT_COUNT_STEP};
            end
        end
        if (cmd.shift_len)
        begin
            win_next = (win_reg << 64) | {448'd0, bits_reg};
        end
        if (cmd.comp_load)
        begin
            work_next = chain_reg;
            rnd_next  = '0;
        end
        if (cmd.round)
        begin
            win_next     = {win_reg[1:15], sched_w};
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
            rnd_next     = rnd_reg + 6'd1;
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
            fill_next = '0;
        end
        if (cmd.restart)
        begin
            chain_next = INIT_HASH;
            fill_next  = '0;
            bits_next  = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        emit_idx_next  = emit_idx_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = chain_reg[emit_idx_reg];
            out_idx_next   = emit_idx_reg;
            emit_idx_next  = emit_idx_reg + 3'd1;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= INIT_HASH;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            rnd_reg       <= rnd_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        work_reg     <= work_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign digest_word   = out_word_reg;
    assign word_index    = out_idx_reg;
    assign last_word     = (out_idx_reg == 3'(CHAIN_WORDS - 1));

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// a byte beat shifts in one byte; a full 64-byte block then passes through the
// compression unit (load, 64 rounds at one per cycle, fold)
// end of message: 0x80, zero bytes to the length slot, the length, then compression
// (one more, with zero fill, on a spill); 8 digest beats, one per cycle unless stalled
// reset: asynchronous, clears counters, state and output valid, loads the initial hash
// top level; instantiates sha256bsh_ctrl and sha256bsh_datapath, uses sha256bsh_pkg
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_axis_tlast    // last_word
);
    import sha256bsh_pkg::*;

    sha_cmd_t    cmd;
    sha_stat_t   stat;
    logic [31:0] digest_word;
    logic [2:0]  word_index;

    sha256bsh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    sha256bsh_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .data_byte     (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .digest_word   (digest_word),
        .word_index    (word_index),
        .last_word     (m_axis_tlast)
    );

    // pack the output beat
    assign m_axis_tdata = {5'd0, word_index, digest_word};

endmodule

// ----- rtl/sha256bsh_checker.sv -----
// port-level checker of the sha-256 byte stream hasher, bound to the top level
// depends on sha256_byte_stream_hasher_defines.svh for the assertion macros
`include "sha256_byte_stream_hasher_defines.svh"

module sha256bsh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled output beat holds
    `SHA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")

    // tlast marks word seven only
    `SHA_ASSERT_SAME(a_last_idx, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd7), "tlast does not match word index")

    // digest words follow back to back in order
    `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1), "digest word skipped or out of order")

    // no input taken while a digest is still being sent
    `SHA_ASSERT_SAME(a_busy_digest, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during digest output")

endmodule

bind sha256_byte_stream_hasher sha256bsh_checker u_sha256bsh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
